@@ rtl/mwas_pkg.sv @@
// shared types, constants and helpers for the multiplicative weights action selector
// no dependencies; used by every module in rtl/
package mwas_pkg;

    localparam int MAX_ACTIONS = 64;
    localparam int IDX_W       = $clog2(MAX_ACTIONS);
    localparam int NUM_W       = 7;
    localparam int ADDR_W      = 3;
    localparam int SUM_W       = 40;
    localparam int QUO_W       = 33;

    localparam logic [15:0]      STEP_RESET    = 16'd32768;
    localparam logic [NUM_W-1:0] ACTIONS_RESET = NUM_W'(MAX_ACTIONS);
    localparam logic [16:0]      LOSS_ONE      = 17'd65536;

    localparam logic OP_LOSS = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic REG_STEP = 1'b0;
    localparam logic REG_NUM  = 1'b1;

    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_DRAW   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UNI,
        S_DISPATCH,
        S_LOSS_MUL,
        S_LOSS_WR,
        S_NORM_RD,
        S_NORM_WAIT,
        S_NORM_DIV,
        S_NORM_WR,
        S_DRAW_RD,
        S_DRAW_CMP
    } state_t;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic             clear;
        logic [IDX_W-1:0] addr;
        logic [31:0]      wdata;
    } mem_req_t;

    function automatic logic [31:0] sat_q32(input logic [QUO_W-1:0] q);
        logic [31:0] r;
        r = q[QUO_W-1] ? 32'hFFFF_FFFF : q[31:0];
        return r;
    endfunction

    function automatic logic [NUM_W-1:0] clamp_num(input logic [NUM_W-1:0] v);
        logic [NUM_W-1:0] r;
        if (v == '0)
        begin
            r = NUM_W'(1);
        end
        else if (v > NUM_W'(MAX_ACTIONS))
        begin
            r = NUM_W'(MAX_ACTIONS);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ rtl/multiplicative_weights_action_select_core.sv @@
// top level: sequencer, config registers, multiplier path for the hedge weight learner
// depends on mwas_pkg, mwas_div, mwas_mem
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  item in   | start, busy            | opcode, loss_value, random_fraction
//  result    | done (one-cycle strobe)| result_kind, action
//  config    | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
//  loss element, not last: read, multiply, write back
//  last loss element: if the sum is nonzero, per action a read, shared-divider divide, write
//  draw: a read and a compare per weight walked, one memory read port
//  first item after reset or a num_actions write: preceded by the uniform divide
//  reset is asynchronous and needs no clearing pass; results cannot be stalled
module multiplicative_weights_action_select_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [16:0] loss_value,
    input  logic [15:0] random_fraction,
    output logic        done,
    output logic [1:0]  result_kind,
    output logic [6:0]  action,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [mwas_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = mwas_pkg::IDX_W;
    localparam int NW = mwas_pkg::NUM_W;
    localparam int SW = mwas_pkg::SUM_W;

    mwas_pkg::state_t state_reg, state_next;

    logic          op_reg;
    logic [16:0]   loss_reg;
    logic [15:0]   rnd_reg;
    logic [IW-1:0] elem_reg, elem_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [SW-1:0] rsum_reg, rsum_next;
    logic [SW-1:0] dsum_reg, dsum_next;
    logic [32:0]   prod_reg;
    logic [31:0]   w_reg;
    logic [31:0]   uni_reg, uni_next;
    logic          uni_ok_reg, uni_ok_next;
    logic [15:0]   step_reg, step_next;
    logic [NW-1:0] num_reg, num_next;
    logic          done_reg, done_next;
    logic [1:0]    kind_reg, kind_next;
    logic [6:0]    action_reg, action_next;

    logic                   cfg_wr;
    logic                   accept;
    mwas_pkg::mem_req_t     mreq;
    logic [31:0]            mdata;
    logic                   div_start;
    logic [31:0]            div_num;
    logic [SW-1:0]          div_den;
    logic                   div_done;
    logic [mwas_pkg::QUO_W-1:0] div_q;
    logic [32:0]            factor;
    logic [64:0]            mprod;
    logic [SW-1:0]          sum_new;
    logic [SW-1:0]          dsum_new;
    logic                   idx_last;
    logic [IW-1:0]          cur_idx;

    assign cfg_wr   = psel && penable && pwrite;
    assign accept   = start && !busy;
    assign busy     = state_reg != mwas_pkg::S_IDLE;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == mwas_pkg::REG_NUM) ? 32'(num_reg) : 32'(step_reg);

    assign factor   = 33'h1_0000_0000 - prod_reg;
    assign mprod    = mdata * factor;
    assign sum_new  = rsum_reg + SW'(w_reg);
    assign dsum_new = dsum_reg + SW'(mdata);
    assign idx_last = (NW'(idx_reg) + NW'(1)) >= num_reg;
    assign cur_idx  = (NW'(elem_reg) >= num_reg) ? '0 : elem_reg;

    assign div_num  = (state_reg == mwas_pkg::S_IDLE) ? 32'd1 : mdata;
    assign div_den  = (state_reg == mwas_pkg::S_IDLE || state_reg == mwas_pkg::S_UNI)
                      ? SW'(num_reg) : rsum_reg;

    mwas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    mwas_mem u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (mreq),
        .uni_weight (uni_reg),
        .num        (num_reg),
        .rdata      (mdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mwas_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = uni_ok_reg ? mwas_pkg::S_DISPATCH : mwas_pkg::S_UNI;
                end
            end
            mwas_pkg::S_UNI:
            begin
                if (div_done)
                begin
                    state_next = mwas_pkg::S_DISPATCH;
                end
            end
            mwas_pkg::S_DISPATCH:
            begin
                if (op_reg == mwas_pkg::OP_DRAW)
                begin
                    state_next = mwas_pkg::S_DRAW_RD;
                end
                else if (loss_reg > mwas_pkg::LOSS_ONE)
                begin
                    state_next = mwas_pkg::S_IDLE;
                end
                else
                begin
                    state_next = mwas_pkg::S_LOSS_MUL;
                end
            end
            mwas_pkg::S_LOSS_MUL:  state_next = mwas_pkg::S_LOSS_WR;
            mwas_pkg::S_LOSS_WR:
            begin
                if (idx_last && sum_new != '0)
                begin
                    state_next = mwas_pkg::S_NORM_RD;
                end
                else
                begin
                    state_next = mwas_pkg::S_IDLE;
                end
            end
            mwas_pkg::S_NORM_RD:   state_next = mwas_pkg::S_NORM_WAIT;
            mwas_pkg::S_NORM_WAIT: state_next = mwas_pkg::S_NORM_DIV;
            mwas_pkg::S_NORM_DIV:
            begin
                if (div_done)
                begin
                    state_next = mwas_pkg::S_NORM_WR;
                end
            end
            mwas_pkg::S_NORM_WR:
            begin
                state_next = idx_last ? mwas_pkg::S_IDLE : mwas_pkg::S_NORM_RD;
            end
            mwas_pkg::S_DRAW_RD:   state_next = mwas_pkg::S_DRAW_CMP;
            mwas_pkg::S_DRAW_CMP:
            begin
                if ({8'd0, rnd_reg, 16'd0} < dsum_new || idx_last)
                begin
                    state_next = mwas_pkg::S_IDLE;
                end
                else
                begin
                    state_next = mwas_pkg::S_DRAW_RD;
                end
            end
            default:               state_next = mwas_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        elem_next   = elem_reg;
        idx_next    = idx_reg;
        rsum_next   = rsum_reg;
        dsum_next   = dsum_reg;
        uni_next    = uni_reg;
        uni_ok_next = uni_ok_reg;
        step_next   = step_reg;
        num_next    = num_reg;
        done_next   = 1'b0;
        kind_next   = kind_reg;
        action_next = action_reg;
        div_start   = 1'b0;
        mreq        = '0;
        mreq.addr   = idx_reg;

        if (cfg_wr)
        begin
            if (paddr[2] == mwas_pkg::REG_STEP)
            begin
                step_next = pwdata[15:0];
            end
            else
            begin
                num_next    = mwas_pkg::clamp_num(pwdata[NW-1:0]);
                uni_ok_next = 1'b0;
                elem_next   = '0;
                rsum_next   = '0;
                mreq.clear  = 1'b1;
            end
        end

        case (state_reg)
            mwas_pkg::S_IDLE:
            begin
                if (accept && !uni_ok_reg)
                begin
                    div_start = 1'b1;
                end
            end
            mwas_pkg::S_UNI:
            begin
                if (div_done)
                begin
                    uni_next    = mwas_pkg::sat_q32(div_q);
                    uni_ok_next = 1'b1;
                end
            end
            mwas_pkg::S_DISPATCH:
            begin
                idx_next  = '0;
                dsum_next = '0;
                if (op_reg == mwas_pkg::OP_LOSS)
                begin
                    if (loss_reg > mwas_pkg::LOSS_ONE)
                    begin
                        elem_next   = '0;
                        rsum_next   = '0;
                        done_next   = 1'b1;
                        kind_next   = mwas_pkg::KIND_ERROR;
                        action_next = '0;
                    end
                    else
                    begin
                        idx_next   = cur_idx;
                        mreq.rd_en = 1'b1;
                        mreq.addr  = cur_idx;
                        if (NW'(elem_reg) >= num_reg)
                        begin
                            rsum_next = '0;
                        end
                    end
                end
            end
            mwas_pkg::S_LOSS_WR:
            begin
                mreq.wr_en = 1'b1;
                mreq.wdata = w_reg;
                rsum_next  = sum_new;
                if (idx_last)
                begin
                    idx_next = '0;
                    if (sum_new == '0)
                    begin
                        mreq.clear  = 1'b1;
                        elem_next   = '0;
                        rsum_next   = '0;
                        done_next   = 1'b1;
                        kind_next   = mwas_pkg::KIND_UPDATE;
                        action_next = '0;
                    end
                end
                else
                begin
                    elem_next = idx_reg + IW'(1);
                end
            end
            mwas_pkg::S_NORM_RD:
            begin
                mreq.rd_en = 1'b1;
            end
            mwas_pkg::S_NORM_WAIT:
            begin
                div_start = 1'b1;
            end
            mwas_pkg::S_NORM_WR:
            begin
                mreq.wr_en = 1'b1;
                mreq.wdata = mwas_pkg::sat_q32(div_q);
                if (idx_last)
                begin
                    elem_next   = '0;
                    rsum_next   = '0;
                    done_next   = 1'b1;
                    kind_next   = mwas_pkg::KIND_UPDATE;
                    action_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            mwas_pkg::S_DRAW_RD:
            begin
                mreq.rd_en = 1'b1;
            end
            mwas_pkg::S_DRAW_CMP:
            begin
                dsum_next = dsum_new;
                if ({8'd0, rnd_reg, 16'd0} < dsum_new)
                begin
                    done_next   = 1'b1;
                    kind_next   = mwas_pkg::KIND_DRAW;
                    action_next = 7'(idx_reg) + 7'd1;
                end
                else if (idx_last)
                begin
                    done_next   = 1'b1;
                    kind_next   = mwas_pkg::KIND_DRAW;
                    action_next = 7'(num_reg);
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mwas_pkg::S_IDLE;
            elem_reg   <= '0;
            rsum_reg   <= '0;
            uni_ok_reg <= 1'b0;
            step_reg   <= mwas_pkg::STEP_RESET;
            num_reg    <= mwas_pkg::ACTIONS_RESET;
            done_reg   <= 1'b0;
            kind_reg   <= mwas_pkg::KIND_UPDATE;
            action_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            elem_reg   <= elem_next;
            rsum_reg   <= rsum_next;
            uni_ok_reg <= uni_ok_next;
            step_reg   <= step_next;
            num_reg    <= num_next;
            done_reg   <= done_next;
            kind_reg   <= kind_next;
            action_reg <= action_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            loss_reg <= loss_value;
            rnd_reg  <= random_fraction;
        end
        idx_reg  <= idx_next;
        dsum_reg <= dsum_next;
        uni_reg  <= uni_next;
        if (state_reg == mwas_pkg::S_DISPATCH)
        begin
            prod_reg <= 33'(step_reg) * 33'(loss_reg);
        end
        if (state_reg == mwas_pkg::S_LOSS_MUL)
        begin
            w_reg <= mprod[63:32];
        end
    end

    assign done        = done_reg;
    assign result_kind = kind_reg;
    assign action      = action_reg;

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result strobes in a row");

    a_draw_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind == mwas_pkg::KIND_DRAW) |->
        (action >= 7'd1 && action <= 7'(num_reg)))
        else $error("drawn action out of range");

    a_action_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind != mwas_pkg::KIND_DRAW) |-> action == 7'd0)
        else $error("action nonzero on non-draw result");

    a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
        NW'(elem_reg) < num_reg)
        else $error("element index beyond num_actions");

endmodule

@@ rtl/mwas_div.sv @@
// shared restoring divider: floor(dividend * 2^32 / divisor), one quotient bit per cycle
// depends on mwas_pkg; dividend must not exceed divisor
module mwas_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [31:0]                   dividend,
    input  logic [mwas_pkg::SUM_W-1:0]    divisor,
    output logic                          done,
    output logic [mwas_pkg::QUO_W-1:0]    quotient
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [5:0]                   cnt_reg;
    logic [mwas_pkg::SUM_W-1:0]   rem_reg;
    logic [mwas_pkg::QUO_W-1:0]   quo_reg;
    logic                         lsb_reg;
    logic [mwas_pkg::SUM_W:0]     trial;
    logic [mwas_pkg::SUM_W:0]     diff;
    logic                         ge;

    assign trial = {rem_reg, lsb_reg};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(mwas_pkg::QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= mwas_pkg::SUM_W'(dividend[31:1]);
            lsb_reg <= dividend[0];
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[mwas_pkg::SUM_W-1:0] : trial[mwas_pkg::SUM_W-1:0];
            lsb_reg <= 1'b0;
            quo_reg <= {quo_reg[mwas_pkg::QUO_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/mwas_mem.sv @@
// weight store: 64 x Q0.32 memory with per-entry valid bits, registered read
// depends on mwas_pkg; entries not written since the last clear read as uniform below num, else as zero
module mwas_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mwas_pkg::mem_req_t            req,
    input  logic [31:0]                   uni_weight,
    input  logic [mwas_pkg::NUM_W-1:0]    num,
    output logic [31:0]                   rdata
);

    logic [31:0]                     mem [mwas_pkg::MAX_ACTIONS];
    logic [mwas_pkg::MAX_ACTIONS-1:0] valid_reg;
    logic [31:0]                     data_reg;
    logic                            rd_valid_reg;
    logic                            rd_range_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            data_reg     <= mem[req.addr];
            rd_valid_reg <= valid_reg[req.addr];
            rd_range_reg <= {1'b0, req.addr} < num;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clear)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.addr] <= 1'b1;
        end
    end

    assign rdata = rd_valid_reg ? data_reg : (rd_range_reg ? uni_weight : 32'd0);

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for multiplicative_weights_action_select_core
// holds a hedge weight scoreboard class and the drivers; depends on mwas_pkg and the rtl
module tb_top;
    import mwas_pkg::*;

    typedef struct {
        logic [1:0] kind;
        logic [6:0] act;
    } hedge_result_t;

    class hedge_scoreboard;
        logic [31:0]   weights[MAX_ACTIONS];
        int unsigned   vec_idx;
        logic [39:0]   wsum;
        logic [15:0]   eta;
        int unsigned   n_act;
        hedge_result_t expected_q[$];
        int            mismatches;

        function void make_uniform();
            logic [63:0] u;
            u = 64'h1_0000_0000 / n_act;
            if (u > 64'hFFFF_FFFF)
            begin
                u = 64'hFFFF_FFFF;
            end
            for (int i = 0; i < MAX_ACTIONS; i++)
            begin
                weights[i] = (i < n_act) ? u[31:0] : 32'd0;
            end
            vec_idx = 0;
            wsum = '0;
        endfunction

        function void reset_state();
            eta = 16'd32768;
            n_act = MAX_ACTIONS;
            mismatches = 0;
            make_uniform();
        endfunction

        function void write_reg(logic idx, logic [31:0] val);
            int unsigned v;
            if (idx == REG_STEP)
            begin
                eta = val[15:0];
            end
            else
            begin
                v = val[6:0];
                n_act = (v == 0) ? 1 : (v > MAX_ACTIONS) ? MAX_ACTIONS : v;
                make_uniform();
            end
        endfunction

        function void normalize();
            logic [63:0] q;
            if (wsum == '0)
            begin
                make_uniform();
                return;
            end
            for (int i = 0; i < n_act; i++)
            begin
                q = {weights[i], 32'd0} / {24'd0, wsum};
                weights[i] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            end
            vec_idx = 0;
            wsum = '0;
        endfunction

        function void note_item(logic op, logic [16:0] loss, logic [15:0] rnd);
            hedge_result_t res;
            logic [63:0]   r;
            logic [63:0]   s;
            logic [63:0]   factor;
            logic [95:0]   prod;
            logic [31:0]   w;
            int unsigned   idx;
            if (op == OP_DRAW)
            begin
                r = {32'd0, rnd, 16'd0};
                s = '0;
                res.kind = KIND_DRAW;
                res.act = n_act[6:0];
                for (int i = 0; i < n_act; i++)
                begin
                    s = s + weights[i];
                    if (r < s)
                    begin
                        res.act = 7'(i + 1);
                        break;
                    end
                end
                expected_q.push_back(res);
                return;
            end
            if (loss > LOSS_ONE)
            begin
                vec_idx = 0;
                wsum = '0;
                res.kind = KIND_ERROR;
                res.act = '0;
                expected_q.push_back(res);
                return;
            end
            idx = vec_idx;
            if (idx >= n_act)
            begin
                idx = 0;
                wsum = '0;
            end
            factor = 64'h1_0000_0000 - 64'(eta) * 64'(loss);
            prod = 96'(weights[idx]) * 96'(factor);
            w = prod[63:32];
            weights[idx] = w;
            wsum = wsum + 40'(w);
            if (idx + 1 >= n_act)
            begin
                normalize();
                res.kind = KIND_UPDATE;
                res.act = '0;
                expected_q.push_back(res);
            end
            else
            begin
                vec_idx = idx + 1;
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [6:0] act);
            hedge_result_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d action %0d", kind, act);
                return;
            end
            e = expected_q.pop_front();
            if (kind !== e.kind || act !== e.act)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected kind %0d action %0d, got kind %0d action %0d",
                             e.kind, e.act, kind, act);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [16:0] loss_value;
    logic [15:0] random_fraction;
    logic        done;
    logic [1:0]  result_kind;
    logic [6:0]  action;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hedge_scoreboard sb;
    int              idle_pct;

    multiplicative_weights_action_select_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .loss_value      (loss_value),
        .random_fraction (random_fraction),
        .done            (done),
        .result_kind     (result_kind),
        .action          (action),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("multiplicative_weights_action_select_core test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_item(opcode, loss_value, random_fraction);
            if (done)
                sb.check_result(result_kind, action);
        end
    end

    task automatic send_item(logic op, logic [16:0] loss, logic [15:0] rnd);
        int gap;
        start <= 1'b1;
        opcode <= op;
        loss_value <= loss;
        random_fraction <= rnd;
        do @(posedge clk); while (busy);
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(4, 1) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (64) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx * 4);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic random_item();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            send_item(OP_DRAW, 17'($urandom), 16'($urandom));
        else if (pick < 20)
            send_item(OP_LOSS, 17'($urandom_range(131071, 65537)), 16'($urandom));
        else if (pick < 30)
            send_item(OP_LOSS, ($urandom_range(1)) ? LOSS_ONE : 17'd0, 16'($urandom));
        else
            send_item(OP_LOSS, 17'($urandom_range(65536)), 16'($urandom));
    endtask

    initial
    begin
        int          n_cfg;
        logic [31:0] step_cfg;
        sb = new();
        sb.reset_state();
        rst_n = 1'b0;
        start = 1'b0;
        opcode = 1'b0;
        loss_value = '0;
        random_fraction = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: draws at reset weights, the two-action corner cases, then clamped num_actions writes
        send_item(OP_DRAW, '0, 16'h0000);
        send_item(OP_DRAW, '0, 16'hFFFF);
        write_reg(REG_STEP, 32'd65535);
        write_reg(REG_NUM, 32'd2);
        send_item(OP_DRAW, '0, 16'h0000);
        send_item(OP_DRAW, '0, 16'hFFFF);
        send_item(OP_LOSS, 17'd0, 16'h0);
        send_item(OP_DRAW, '0, 16'h8000);
        send_item(OP_LOSS, LOSS_ONE, 16'h0);
        send_item(OP_LOSS, 17'd0, 16'h0);
        send_item(OP_LOSS, LOSS_ONE, 16'h0);
        send_item(OP_LOSS, LOSS_ONE, 16'h0);
        send_item(OP_LOSS, 17'h1FFFF, 16'h0);
        send_item(OP_LOSS, LOSS_ONE, 16'h0);
        send_item(OP_LOSS, 17'd0, 16'h0);
        send_item(OP_LOSS, LOSS_ONE, 16'h0);
        send_item(OP_LOSS, 17'd65537, 16'h0);
        send_item(OP_DRAW, '0, 16'hFFFF);
        write_reg(REG_STEP, 32'd0);
        write_reg(REG_NUM, 32'd0);
        send_item(OP_LOSS, LOSS_ONE, 16'h0);
        send_item(OP_DRAW, 17'h1FFFF, 16'hFFFF);
        write_reg(REG_STEP, 32'd1);
        write_reg(REG_NUM, 32'd127);
        send_item(OP_LOSS, 17'd12345, 16'h0);
        send_item(OP_DRAW, '0, 16'h5555);

        // random phases over several settings
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: idle_pct = 0;
                1: idle_pct = 69;
                2: idle_pct = 0;
                default: idle_pct = 18;
            endcase
            case (p)
                0: step_cfg = 32'd65535;
                1: step_cfg = 32'd1;
                2: step_cfg = 32'd0;
                default: step_cfg = $urandom;
            endcase
            case (p)
                0: n_cfg = 3;
                1: n_cfg = 1;
                2: n_cfg = 2;
                3: n_cfg = 64;
                4: n_cfg = 127;
                default: n_cfg = $urandom_range(12, 1);
            endcase
            write_reg(REG_STEP, step_cfg);
            write_reg(REG_NUM, 32'(n_cfg));
            for (int k = 0; k < 66; k++)
                random_item();
        end

        start <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("multiplicative_weights_action_select_core test passed");
        else
            $display("multiplicative_weights_action_select_core test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mwas_pkg.sv
rtl/mwas_div.sv
rtl/mwas_mem.sv
rtl/multiplicative_weights_action_select_core.sv
tb/sv/tb_top.sv
